/* rtl/core/aog_pkg.sv */
`default_nettype none
package aog_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 24;
  localparam int BLOCK_LEN       = 1024;

  localparam int TBL_Q      = 1 << (SINE_TABLE_BITS - 2);
  localparam int STEP_W     = 48;
  localparam int TIME_W     = 32;
  localparam int POS_W      = 10;
  localparam int ACC_W      = 36;
  localparam int PROD_W     = 34;
  localparam int POS100_W   = POS_W + 7;
  localparam int FADE_LIMIT = 3 * BLOCK_LEN;
  localparam int FADE_W     = $clog2(FADE_LIMIT);
  localparam int FADE_SH    = $clog2(BLOCK_LEN);
  localparam int FPROD_W    = ACC_W + FADE_W;
  localparam int QIN_W      = FPROD_W - FADE_SH;
  localparam int RCP_K      = 37;
  localparam int RCP_M_W    = 36;
  localparam int RCP_HALF   = RCP_M_W / 2;
  localparam int RCP_P_W    = QIN_W + RCP_M_W;
  localparam int AP_W       = ACC_W + 17;
  localparam int ROUND_SH   = 47 - SAMPLE_BITS;
  localparam int HARM_W     = 5;

  // floor(y / 3) = (y * RCP_M) >> RCP_K, exact for y below 2^RCP_K
  localparam logic [RCP_M_W-1:0] RCP_M = RCP_M_W'(((longint'(1) <<< RCP_K) + 1) / 3);

  localparam longint Q30_ONE = longint'(1) << 30;

  typedef logic signed [15:0] sine_t;
  typedef logic signed [17:0] weight_t;
  typedef sine_t qrom_t [0:TBL_Q];

  typedef enum logic [2:0] {
    WAVE_SILENT = 3'd0,
    WAVE_SINE   = 3'd1,
    WAVE_SAW    = 3'd2,
    WAVE_SQR    = 3'd3,
    WAVE_TRI    = 3'd4
  } wave_t;

  typedef enum logic [2:0] {
    REG_AMPLITUDE = 3'd0,
    REG_TARGET    = 3'd1,
    REG_WAVEFORM  = 3'd2,
    REG_RATIO     = 3'd3,
    REG_SNAP      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              load_item;
    logic              mul_lo;
    logic              mul_hi;
    logic              harm_issue;
    logic [HARM_W-1:0] harm_k;
    logic              pass_sel;
    logic              pass_end;
    logic              glide_mul;
    logic              glide_upd;
    logic              fade_mul;
    logic              rcp_lo;
    logic              rcp_hi;
    logic              div_end;
    logic              amp_mul;
    logic              out_load;
  } aog_cmd_t;

  typedef struct packed {
    logic [HARM_W-1:0] harm_cnt;
    logic              on_target;
    logic              pipe_busy;
    logic              fade_act;
    logic              out_free;
  } aog_sts_t;

  localparam weight_t SAW_WT [16] = '{
    18'sd65536, 18'sd32768, 18'sd21845, 18'sd16384, 18'sd13107, 18'sd10923,
    18'sd9362,  18'sd8192,  18'sd7282,  18'sd6554,  18'sd5958,  18'sd5461,
    18'sd5041,  18'sd4681,  18'sd4369,  18'sd4096};
  localparam weight_t SQ_WT [16] = '{
    18'sd65536, 18'sd21845, 18'sd13107, 18'sd9362, 18'sd7282, 18'sd5958,
    18'sd5041,  18'sd4369,  18'sd3855,  18'sd3449, 18'sd0,    18'sd0,
    18'sd0,     18'sd0,     18'sd0,     18'sd0};
  localparam weight_t TRI_WT [8] = '{
    18'sd65536, -18'sd7282, 18'sd2621, -18'sd1337, 18'sd809, -18'sd542,
    18'sd0, 18'sd0};

  function automatic logic [HARM_W-1:0] harm_count(logic [2:0] w);
    logic [HARM_W-1:0] c;
    case (w)
      WAVE_SINE: c = HARM_W'(1);
      WAVE_SAW:  c = HARM_W'(16);
      WAVE_SQR:  c = HARM_W'(10);
      WAVE_TRI:  c = HARM_W'(6);
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic weight_t harm_weight(logic [2:0] w, logic [HARM_W-1:0] k);
    weight_t r;
    case (w)
      WAVE_SINE: r = 18'sd65536;
      WAVE_SAW:  r = SAW_WT[k[3:0]];
      WAVE_SQR:  r = SQ_WT[k[3:0]];
      WAVE_TRI:  r = TRI_WT[k[2:0]];
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b) / Q30_ONE;
  endfunction

  // integer taylor polynomial of the quarter wave, evaluated at elaboration
  function automatic sine_t quarter_sine(int m);
    longint u;
    longint u2;
    longint acc;
    longint r;
    u   = longint'(m) <<< (30 - (SINE_TABLE_BITS - 2));
    u2  = mul_q30(u, u);
    acc = -3864;
    acc = 172272 + mul_q30(acc, u2);
    acc = -5026994 + mul_q30(acc, u2);
    acc = 85569306 + mul_q30(acc, u2);
    acc = -693598669 + mul_q30(acc, u2);
    acc = 1686629713 + mul_q30(acc, u2);
    acc = mul_q30(acc, u);
    if (acc < 0) acc = 0;
    r = (acc * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (r > 32767) r = 32767;
    return sine_t'(r);
  endfunction

  function automatic qrom_t build_qrom();
    qrom_t t;
    for (int i = 0; i <= TBL_Q; i++) t[i] = quarter_sine(i);
    return t;
  endfunction

  localparam qrom_t QROM = build_qrom();

endpackage
`default_nettype wire

/* rtl/core/additive_oscillator_with_glide_core.sv */
`default_nettype none
// additive oscillator with glide: one audio sample per input transaction
// in_*  : one transaction per sample tick; in_tdata carries sample_time and
//         block_pos, the item is taken when in_tvalid and in_tready are high
// out_* : one transaction per input with the saturated signed sample
// cfg_* : register writes (amplitude, target_step, waveform, glide_ratio,
//         snap_threshold); cfg_ready is always high, write only while idle
// one item is in work at a time; each item walks the n harmonics of its
// waveform (sine 1, saw 16, square 10, triangle 6), twice while the
// frequency glides (two harmonic passes plus the glide update), and samples
// inside a fade-in add scale, divide by three as a two-step reciprocal
// multiply, and sign; silent samples skip the harmonics.
// harmonics go through one pipelined table read and multiply-accumulate,
// one per cycle
// the finished sample sits in an output register; a stalled receiver only
// holds the next item in its last step, the input side stays open until then
// reset (rst_n low at a clock edge) restores register defaults, zero
// frequency and clears the output valid
module additive_oscillator_with_glide_core
  import aog_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] sample_time, [41:32] block_pos
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [23:0] sample
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  aog_cmd_t cmd;
  aog_sts_t sts;

  assign cfg_ready = 1'b1;

  aog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  aog_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

/* rtl/core/aog_ctrl.sv */
`default_nettype none
module aog_ctrl
  import aog_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire aog_sts_t sts,
  output aog_cmd_t      cmd
);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0_0000_0000_0001,
    ST_MUL_LO    = 13'b0_0000_0000_0010,
    ST_MUL_HI    = 13'b0_0000_0000_0100,
    ST_HARM      = 13'b0_0000_0000_1000,
    ST_DRAIN     = 13'b0_0000_0001_0000,
    ST_GLIDE_MUL = 13'b0_0000_0010_0000,
    ST_GLIDE_UPD = 13'b0_0000_0100_0000,
    ST_FADE_MUL  = 13'b0_0000_1000_0000,
    ST_RCP_LO    = 13'b0_0001_0000_0000,
    ST_RCP_HI    = 13'b0_0010_0000_0000,
    ST_DIV_END   = 13'b0_0100_0000_0000,
    ST_AMP_MUL   = 13'b0_1000_0000_0000,
    ST_OUT       = 13'b1_0000_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [HARM_W-1:0]   k_r, k_nxt;
  logic                pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    cmd.pass_sel = pass_r;
    cmd.harm_k   = k_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        pass_nxt  = 1'b0;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          // silent samples skip straight to scaling with a zero sum
          state_nxt = (sts.harm_cnt == '0) ? ST_AMP_MUL : ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        k_nxt      = '0;
        state_nxt  = ST_HARM;
      end
      ST_HARM: begin
        cmd.harm_issue = 1'b1;
        k_nxt = k_r + HARM_W'(1);
        if (k_r == sts.harm_cnt - HARM_W'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.pass_end = 1'b1;
          if (pass_r) begin
            state_nxt = ST_GLIDE_MUL;
          end else if (!sts.on_target) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_MUL_LO;
          end else begin
            state_nxt = sts.fade_act ? ST_FADE_MUL : ST_AMP_MUL;
          end
        end
      end
      ST_GLIDE_MUL: begin
        cmd.glide_mul = 1'b1;
        state_nxt     = ST_GLIDE_UPD;
      end
      ST_GLIDE_UPD: begin
        cmd.glide_upd = 1'b1;
        state_nxt     = sts.fade_act ? ST_FADE_MUL : ST_AMP_MUL;
      end
      ST_FADE_MUL: begin
        cmd.fade_mul = 1'b1;
        state_nxt    = ST_RCP_LO;
      end
      ST_RCP_LO: begin
        cmd.rcp_lo = 1'b1;
        state_nxt  = ST_RCP_HI;
      end
      ST_RCP_HI: begin
        cmd.rcp_hi = 1'b1;
        state_nxt  = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd.div_end = 1'b1;
        state_nxt   = ST_AMP_MUL;
      end
      ST_AMP_MUL: begin
        cmd.amp_mul = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_harm_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HARM |-> k_r < sts.harm_cnt)
    else $error("harmonic index beyond waveform count");

  a_on_target_single_pass: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN && !sts.pipe_busy && !pass_r && sts.on_target
    |=> state_r != ST_MUL_LO)
    else $error("second pass started with frequency on target");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new item accepted while one is in work");
`endif

endmodule
`default_nettype wire

/* rtl/core/aog_dp.sv */
`default_nettype none
module aog_dp
  import aog_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [47:0] in_tdata,
  input  wire aog_cmd_t    cmd,
  output aog_sts_t         sts,
  input  wire logic        out_tready,
  output logic             out_tvalid,
  output logic [23:0]      out_tdata
);

  // configuration and control state
  logic [15:0]       amp_r;
  logic [31:0]       tgt_r;
  logic [2:0]        wave_r;
  logic [15:0]       ratio_r;
  logic [15:0]       thr_r;
  logic [STEP_W-1:0] cur_r;
  logic              fade_pend_r;
  logic              fading_r;
  logic              v1_r;
  logic              v2_r;
  logic              out_valid_r;

  // payload
  logic [TIME_W-1:0]      t_r;
  logic [POS_W-1:0]       pos_r;
  logic [STEP_W-1:0]      mp_r;
  logic [STEP_W-1:0]      phase_r;
  logic [STEP_W-1:0]      inc_r;
  sine_t                  sine_r;
  weight_t                w_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  sum_r;
  logic [63:0]            gp_r;
  logic [FPROD_W-1:0]     fprod_r;
  logic [RCP_P_W-1:0]     rp_r;
  logic                   neg_r;
  logic signed [AP_W-1:0] ap_r;
  logic [SAMPLE_BITS-1:0] out_r;

  logic [STEP_W-1:0]   tgt48;
  logic [STEP_W-1:0]   step_sel;
  logic [63:0]         mul_lo_p;
  logic [63:0]         mul_hi_p;
  logic [STEP_W-1:0]   phase_new;
  logic                up;
  logic [STEP_W-1:0]   mag;
  logic [STEP_W-1:0]   mv;
  logic [SINE_TABLE_BITS-1:0] tidx;
  logic [SINE_TABLE_BITS-2:0] qidx;
  sine_t               qval;
  sine_t               sval;
  logic [POS100_W-1:0] pos100;
  logic [ACC_W-1:0]    abs_sum;
  logic [QIN_W-1:0]    qin;
  logic [RCP_P_W-1:0]  rcp_lo_p;
  logic [RCP_P_W-1:0]  rcp_hi_p;
  logic signed [ACC_W:0]  pair_sum;
  logic signed [AP_W-1:0] rnd;
  logic signed [AP_W-1:0] shifted;
  logic [SAMPLE_BITS-1:0] sat;

  localparam logic signed [AP_W-1:0] S_MAX =
    AP_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [AP_W-1:0] S_MIN =
    AP_W'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

  assign tgt48     = {tgt_r, 16'b0};
  assign step_sel  = cmd.pass_sel ? tgt48 : cur_r;
  assign mul_lo_p  = 64'(step_sel) * 64'(t_r[15:0]);
  assign mul_hi_p  = 64'(step_sel) * 64'(t_r[31:16]);
  assign phase_new = mp_r + {mul_hi_p[31:0], 16'b0};

  assign up  = tgt48 > cur_r;
  assign mag = up ? (tgt48 - cur_r) : (cur_r - tgt48);
  assign mv  = gp_r[63:16];

  // quarter-wave mirror of the full-period table
  assign tidx = phase_r[STEP_W-1 -: SINE_TABLE_BITS];
  assign qidx = tidx[SINE_TABLE_BITS-2] ?
                ((SINE_TABLE_BITS-1)'(TBL_Q) - {1'b0, tidx[SINE_TABLE_BITS-3:0]}) :
                {1'b0, tidx[SINE_TABLE_BITS-3:0]};
  assign qval = QROM[qidx];
  assign sval = tidx[SINE_TABLE_BITS-1] ? -qval : qval;

  assign pos100  = POS100_W'(pos_r) * POS100_W'(100);
  assign abs_sum = sum_r[ACC_W-1] ? ACC_W'(-sum_r) : ACC_W'(sum_r);
  // divide by the block length first, then by three through the reciprocal
  assign qin      = fprod_r[FPROD_W-1:FADE_SH];
  assign rcp_lo_p = RCP_P_W'(qin) * RCP_P_W'(RCP_M[RCP_HALF-1:0]);
  assign rcp_hi_p = RCP_P_W'(qin) * RCP_P_W'(RCP_M[RCP_M_W-1:RCP_HALF]);
  assign pair_sum = {sum_r[ACC_W-1], sum_r} + {acc_r[ACC_W-1], acc_r};

  assign rnd     = ap_r + AP_W'(longint'(1) <<< (ROUND_SH - 1));
  assign shifted = rnd >>> ROUND_SH;
  always_comb begin
    if (shifted > S_MAX)      sat = S_MAX[SAMPLE_BITS-1:0];
    else if (shifted < S_MIN) sat = S_MIN[SAMPLE_BITS-1:0];
    else                      sat = shifted[SAMPLE_BITS-1:0];
  end

  assign sts.harm_cnt  = harm_count(wave_r);
  assign sts.on_target = cur_r == tgt48;
  assign sts.pipe_busy = v1_r | v2_r;
  assign sts.fade_act  = fading_r && (32'(pos100) < 32'(FADE_LIMIT));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r       <= '0;
      tgt_r       <= '0;
      wave_r      <= WAVE_SILENT;
      ratio_r     <= 16'd32768;
      thr_r       <= 16'd89;
      cur_r       <= '0;
      fade_pend_r <= 1'b0;
      fading_r    <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.harm_issue;
      v2_r <= v1_r;
      if (cmd.load_item && in_tdata[41:32] == '0) begin
        fading_r    <= fade_pend_r;
        fade_pend_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_AMPLITUDE: amp_r <= cfg_data[15:0];
          REG_TARGET: begin
            if (cfg_data != tgt_r) fade_pend_r <= 1'b1;
            tgt_r <= cfg_data;
          end
          REG_WAVEFORM:  wave_r  <= cfg_data[2:0];
          REG_RATIO:     ratio_r <= cfg_data[15:0];
          REG_SNAP:      thr_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.glide_upd) begin
        if (mv < {thr_r, 16'b0}) cur_r <= tgt48;
        else if (up)             cur_r <= cur_r + mv;
        else                     cur_r <= cur_r - mv;
      end
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      t_r   <= in_tdata[31:0];
      pos_r <= in_tdata[41:32];
      sum_r <= '0;
    end
    if (cmd.mul_lo) begin
      mp_r  <= mul_lo_p[STEP_W-1:0];
      acc_r <= '0;
    end
    if (cmd.mul_hi) begin
      phase_r <= phase_new;
      // sawtooth walks every harmonic, the others only odd ones
      inc_r   <= (wave_r == WAVE_SAW) ? phase_new : {phase_new[STEP_W-2:0], 1'b0};
    end
    if (cmd.harm_issue) begin
      sine_r  <= sval;
      w_r     <= harm_weight(wave_r, cmd.harm_k);
      phase_r <= phase_r + inc_r;
    end
    if (v1_r) prod_r <= sine_r * w_r;
    if (v2_r) acc_r  <= acc_r + ACC_W'(prod_r);
    if (cmd.pass_end) begin
      if (cmd.pass_sel) sum_r <= pair_sum[ACC_W:1];
      else              sum_r <= acc_r;
    end
    if (cmd.glide_mul) gp_r <= 64'(mag) * 64'(ratio_r);
    if (cmd.fade_mul) begin
      fprod_r <= FPROD_W'(abs_sum) * FPROD_W'(pos100[FADE_W-1:0]);
      neg_r   <= sum_r[ACC_W-1];
    end
    if (cmd.rcp_lo) rp_r <= rcp_lo_p;
    if (cmd.rcp_hi) rp_r <= rp_r + {rcp_hi_p[RCP_P_W-RCP_HALF-1:0], {RCP_HALF{1'b0}}};
    if (cmd.div_end) begin
      sum_r <= neg_r ? -ACC_W'(rp_r[RCP_P_W-1:RCP_K]) : ACC_W'(rp_r[RCP_P_W-1:RCP_K]);
    end
    if (cmd.amp_mul) ap_r <= AP_W'(sum_r) * $signed({{(AP_W-17){1'b0}}, 1'b0, amp_r});
    if (cmd.out_load) out_r <= sat;
  end

endmodule
`default_nettype wire
